// File: rtl/qpisc_pkg.sv
package qpisc_pkg;

  // Register file layout
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_TICKS   = 2'd0,
    REG_P_GAIN         = 2'd1,
    REG_I_GAIN         = 2'd2,
    REG_INTEGRAL_LIMIT = 2'd3
  } cfg_reg_t;

  // Stream widths
  localparam int unsigned InDataW  = 8;   // pin_a, pin_b, zero fill
  localparam int unsigned InUserW  = 1;   // mode
  localparam int unsigned OutDataW = 16;  // drive_magnitude, drive_forward, zero fill

  // Item kinds carried in tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Register reset values
  localparam logic signed [15:0] TargetReset = 16'sd0;
  localparam logic [14:0]        PGainReset  = 15'd20;
  localparam logic [14:0]        IGainReset  = 15'd10;
  localparam logic [14:0]        ILimitReset = 15'd32767;

  // Drive scaling: terms are divided by 2^DriveShift, magnitude saturates here
  localparam int unsigned DriveShift = 7;
  localparam logic [7:0]  DriveMax   = 8'd255;

endpackage

// File: rtl/quadrature_pi_speed_controller_core.sv
// Incremental PI speed controller driven by quadrature encoder samples and
// control-period ticks on one input stream (tuser selects: 0 pin sample, 1
// tick). A pin sample that differs from the last counted pair moves the
// proportional and clamped integral terms and the period count; it produces
// no output beat. A tick emits one output beat carrying the drive magnitude
// (saturated at 255) and direction, then reloads the proportional term from the
// target, adds the target term to the clamped integral, clears the count. One
// item is accepted every clock cycle unless a tick waits on the output
// register: each item passes an input register and add/compare/clamp logic
// against the controller state, and a tick's beat an output register. The
// target*gain products are held in registers refreshed in the cycle after a
// configuration write. Pin samples keep flowing while a drive beat waits on
// m_tready; a tick in the input register then holds it until the beat is taken.
module quadrature_pi_speed_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [qpisc_pkg::InDataW-1:0]      s_tdata,   // [0] pin_a, [1] pin_b, [7:2] zero
  input  logic [qpisc_pkg::InUserW-1:0]      s_tuser,   // [0] mode
  // drive output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [qpisc_pkg::OutDataW-1:0]     m_tdata,   // [7:0] drive_magnitude,
                                                        // [8] drive_forward, [15:9] zero
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qpisc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [qpisc_pkg::CfgDataW-1:0]     cfg_data
);
  import qpisc_pkg::*;

  // Configuration registers
  logic signed [15:0] target_ticks;
  logic [14:0]        p_gain;
  logic [14:0]        i_gain;
  logic [14:0]        integral_limit;

  // Wrapped target*gain products
  logic signed [15:0] tgt_p;
  logic signed [15:0] tgt_i;

  // Controller state
  logic [1:0]         prev_pins;
  logic signed [15:0] period_count;
  logic signed [15:0] prop_term;
  logic signed [15:0] integ_term;

  // Input register
  logic               in_valid;
  logic               in_mode;
  logic               in_a;
  logic               in_b;

  // Output register
  logic [7:0]         out_mag;
  logic               out_fwd;

  logic               advance;
  logic [15:0]        prod_p;
  logic [15:0]        prod_i;

  assign cfg_ready = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      target_ticks   <= TargetReset;
      p_gain         <= PGainReset;
      i_gain         <= IGainReset;
      integral_limit <= ILimitReset;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_TICKS:   target_ticks   <= $signed(cfg_data);
        REG_P_GAIN:         p_gain         <= cfg_data[14:0];
        REG_I_GAIN:         i_gain         <= cfg_data[14:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[14:0];
        default:            ;
      endcase
    end
  end

  // Products wrap to 16 bits; low bits do not depend on signedness
  assign prod_p = $unsigned(target_ticks) * {1'b0, p_gain};
  assign prod_i = $unsigned(target_ticks) * {1'b0, i_gain};

  always_ff @(posedge clk) begin
    tgt_p <= $signed(prod_p);
    tgt_i <= $signed(prod_i);
  end

  // A tick needs the output register free; a sample never does
  assign advance  = in_valid && (!in_mode || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= s_tuser[0];
      in_a    <= s_tdata[0];
      in_b    <= s_tdata[1];
    end
  end

  // Update logic
  logic [1:0]         pins;
  logic               changed;
  logic               dir_fwd;
  logic               toward;
  logic signed [17:0] ie_w;
  logic signed [17:0] lim_w;
  logic signed [17:0] ig_w;
  logic signed [17:0] ti_w;
  logic signed [15:0] ie_sample;
  logic signed [15:0] ie_tick;
  logic signed [15:0] pe_sample;
  logic signed [15:0] cnt_sample;
  logic signed [16:0] pe_q;
  logic signed [16:0] ie_q;
  logic signed [10:0] drive_sum;
  logic [10:0]        drive_abs;
  logic [7:0]         mag_next;
  logic               fwd_next;

  always_comb begin
    pins    = {in_b, in_a};
    changed = (pins != prev_pins);
    dir_fwd = in_a ^ prev_pins[1];
    toward  = ((period_count < target_ticks) && dir_fwd) ||
              ((period_count > target_ticks) && !dir_fwd);

    ie_w  = 18'(integ_term);
    lim_w = 18'(signed'({1'b0, integral_limit}));
    ig_w  = 18'(signed'({1'b0, i_gain}));
    ti_w  = 18'(tgt_i);

    // Counted sample
    if (toward) begin
      pe_sample = prop_term - $signed({1'b0, p_gain});
      if (ie_w > ig_w - lim_w) begin
        ie_sample = integ_term - $signed({1'b0, i_gain});
      end else begin
        ie_sample = -$signed({1'b0, integral_limit});
      end
    end else begin
      pe_sample = prop_term + $signed({1'b0, p_gain});
      if (ie_w < lim_w - ig_w) begin
        ie_sample = integ_term + $signed({1'b0, i_gain});
      end else begin
        ie_sample = $signed({1'b0, integral_limit});
      end
    end
    cnt_sample = dir_fwd ? period_count + 16'sd1 : period_count - 16'sd1;

    // Tick: integral adds the target term, clamped on the side of the addend
    if (ti_w > 18'sd0) begin
      if (ie_w < lim_w - ti_w) begin
        ie_tick = integ_term + tgt_i;
      end else begin
        ie_tick = $signed({1'b0, integral_limit});
      end
    end else if (ti_w < 18'sd0) begin
      if (ie_w > -lim_w - ti_w) begin
        ie_tick = integ_term + tgt_i;
      end else begin
        ie_tick = -$signed({1'b0, integral_limit});
      end
    end else begin
      ie_tick = integ_term;
    end

    // Drive: each term divided by 128 rounding toward zero
    pe_q = (17'(prop_term) + (prop_term[15] ? 17'sd127 : 17'sd0)) >>> DriveShift;
    ie_q = (17'(integ_term) + (integ_term[15] ? 17'sd127 : 17'sd0)) >>> DriveShift;
    drive_sum = 11'(pe_q) + 11'(ie_q);
    fwd_next  = !drive_sum[10];
    drive_abs = drive_sum[10] ? 11'(-drive_sum) : 11'(drive_sum);
    mag_next  = (drive_abs > 11'(DriveMax)) ? DriveMax : drive_abs[7:0];
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins    <= '0;
      period_count <= '0;
      prop_term    <= '0;
      integ_term   <= '0;
    end else if (advance) begin
      if (in_mode == MODE_TICK) begin
        prop_term    <= tgt_p;
        integ_term   <= ie_tick;
        period_count <= '0;
      end else if (changed) begin
        prop_term    <= pe_sample;
        integ_term   <= ie_sample;
        period_count <= cnt_sample;
        prev_pins    <= pins;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_mode == MODE_TICK) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_mode == MODE_TICK) begin
      out_mag <= mag_next;
      out_fwd <= fwd_next;
    end
  end

  assign m_tdata = {7'd0, out_fwd, out_mag};

endmodule

// File: rtl/qpisc_checker.sv
module qpisc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [qpisc_pkg::OutDataW-1:0] m_tdata
);
  import qpisc_pkg::*;

  // A stalled drive beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("drive beat changed while stalled");

  // Nothing leaves straight after reset, and the input is open
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("drive beat or input stall right after reset");

  // An idle input never closes by itself
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready && !s_tvalid |=> s_tready)
    else $error("input closed with nothing held");

  // A zero drive always reads as forward
  a_zero_fwd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:0] == 8'd0 |-> m_tdata[8])
    else $error("zero drive marked reverse");

  // Fill bits stay clear
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OutDataW-1:9] == '0)
    else $error("fill bits set in drive beat");

endmodule

bind quadrature_pi_speed_controller_core qpisc_checker u_qpisc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
